// ===== rtl/fbgr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bitmap font glyph row unit.
// No dependencies; used by the interfaces, the font RAM and the top level.
package fbgr_pkg;

  localparam int FontBytes = 262144;
  localparam int AddrW     = $clog2(FontBytes);
  localparam int MaxGlyphW = 16;
  localparam int MaxGlyphH = 16;
  localparam int MaskW     = 16;

  // header layout
  localparam int HdrWidthAddr  = 14;
  localparam int HdrHeightAddr = 15;
  localparam int HdrTypeAddr   = 16;
  localparam int SbGlyphBase   = 17;
  localparam int DbCountAddr   = 17;
  localparam int DbBlockBase   = 18;

  localparam logic [7:0] FontSingle = 8'd0;
  localparam logic [7:0] FontDouble = 8'd1;

  // lead-byte ranges of a single-byte code page
  localparam logic [7:0] LeadLo1 = 8'h81;
  localparam logic [7:0] LeadHi1 = 8'h9F;
  localparam logic [7:0] LeadLo2 = 8'hE0;
  localparam logic [7:0] LeadHi2 = 8'hFC;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncDraw = 1'b1;

  typedef enum logic [1:0] {
    StRow      = 2'd0,
    StReject   = 2'd1,
    StTooLarge = 2'd2
  } status_e;

  typedef struct packed {
    logic              func;
    logic [AddrW-1:0]  load_addr;
    logic [7:0]        load_byte;
    logic [15:0]       char_code;
    logic [15:0]       x_pos;
    logic [15:0]       y_pos;
    logic [15:0]       fg_color;
    logic [15:0]       bg_color;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [15:0]       row_x;
    logic [15:0]       row_y;
    logic [MaskW-1:0]  row_mask;
    logic [4:0]        row_width;
    logic [15:0]       row_fg;
    logic [15:0]       row_bg;
    logic              last_row;
  } out_item_t;

  // font RAM access: one write and one read address per cycle
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [7:0]        wdata;
    logic [AddrW-1:0]  raddr;
  } ram_req_t;

endpackage

// ===== rtl/fbgr_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one load or draw item.
// Depends on fbgr_pkg.
interface fbgr_in_if;
  logic               valid;
  logic               ready;
  fbgr_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/fbgr_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying one glyph row result.
// Depends on fbgr_pkg.
interface fbgr_out_if;
  logic                valid;
  logic                ready;
  fbgr_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/fbgr_font_ram.sv =====
`timescale 1ns / 1ps
// Font image store: single-port write, registered read.
// Depends on fbgr_pkg.
module fbgr_font_ram (
  input  logic               clk_i,
  input  fbgr_pkg::ram_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [fbgr_pkg::FontBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bitmap_font_glyph_rows_unit.sv =====
`timescale 1ns / 1ps
// Top level of the bitmap font glyph row unit: sequencer around the font RAM.
// Depends on fbgr_pkg, fbgr_in_if, fbgr_out_if and fbgr_font_ram.
//
//  channel | dir | carries
//  --------+-----+---------------------------------------------------------
//  in_i    | in  | load (address, byte) or draw (code, position, colours)
//  out_o   | out | one glyph row mask per transfer, or a single error result
//
// Sequence: a load is a single RAM write. A draw reads the header, then walks
// the code blocks (double-byte fonts only), then reads each glyph row; the
// single RAM read port sets this, as every header, block and glyph byte is a
// separate read. Errors are handed over from StErr once found. Reset clears
// the sequencer and output valid only; the font image is undefined until
// loaded and has no clearing pass. A stalled output holds its row in the
// output register while the sequencer waits for it.
module bitmap_font_glyph_rows_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  fbgr_in_if.sink         in_i,
  fbgr_out_if.source      out_o
);

  localparam int AW = fbgr_pkg::AddrW;

  // sequencer states
  localparam logic [3:0] StIdle = 4'd0;   // accept loads and draws
  localparam logic [3:0] StHdrW = 4'd1;   // width byte arriving
  localparam logic [3:0] StHdrH = 4'd2;   // height byte arriving
  localparam logic [3:0] StHdrT = 4'd3;   // type byte arriving
  localparam logic [3:0] StChk  = 4'd4;   // header checks, block count arriving
  localparam logic [3:0] StBlk  = 4'd5;   // start of one code block
  localparam logic [3:0] StB1   = 4'd6;
  localparam logic [3:0] StB2   = 4'd7;
  localparam logic [3:0] StB3   = 4'd8;
  localparam logic [3:0] StB4   = 4'd9;   // block end complete, compare
  localparam logic [3:0] StMul  = 4'd10;  // glyph base from index
  localparam logic [3:0] StRow  = 4'd11;  // read first row byte
  localparam logic [3:0] StR1   = 4'd12;
  localparam logic [3:0] StR2   = 4'd13;
  localparam logic [3:0] StEmit = 4'd14;  // hand row to output register
  localparam logic [3:0] StErr  = 4'd15;  // hand error result over

  logic [3:0]  state_q, state_d;
  logic [15:0] code_q, code_d;
  logic [15:0] x_q, x_d, y_q, y_d, fg_q, fg_d, bg_q, bg_d;
  logic [7:0]  w_q, w_d, h_q, h_d, type_q, type_d;
  logic [7:0]  nb_q, nb_d, blk_q, blk_d, ce_lo_q, ce_lo_d;
  logic [15:0] cs_q, cs_d;
  logic [AW-1:0] idx_q, idx_d, row_addr_q, row_addr_d;
  logic [4:0]  k_q, k_d;
  logic [7:0]  b0_q, b0_d, b1_q, b1_d;
  fbgr_pkg::status_e err_q, err_d;
  fbgr_pkg::out_item_t out_q, out_d;
  logic        out_valid_q, out_valid_d;

  fbgr_pkg::ram_req_t ram_req;
  logic [7:0]  rdata;

  fbgr_font_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  // handshakes
  logic in_xfer, slot_free;
  assign in_xfer   = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;

  // glyph geometry: bytes per row is 1 or 2, bytes per glyph a shift of h
  logic        two_bytes;
  logic [1:0]  wb;
  logic [5:0]  wbh;
  assign two_bytes = (w_q > 8'd8);
  assign wb        = two_bytes ? 2'd2 : 2'd1;
  assign wbh       = two_bytes ? {h_q[4:0], 1'b0} : {1'b0, h_q[4:0]};

  // header checks
  logic bad_hdr, too_large, bad_sb_code;
  assign bad_hdr     = (type_q > fbgr_pkg::FontDouble) || (w_q == 8'd0) || (h_q == 8'd0);
  assign too_large   = (w_q > 8'(fbgr_pkg::MaxGlyphW)) || (h_q > 8'(fbgr_pkg::MaxGlyphH));
  assign bad_sb_code = (code_q[15:8] != 8'd0) ||
                       (code_q[7:0] inside {[fbgr_pkg::LeadLo1:fbgr_pkg::LeadHi1],
                                            [fbgr_pkg::LeadLo2:fbgr_pkg::LeadHi2]});

  // first glyph byte address of the bottom row: base + (h-1)*wb
  logic [14:0] sb_prod;
  logic [AW-1:0] sb_first, db_first, db_prod, blk_addr;
  assign sb_prod  = ({1'b0, code_q[7:0]} + 9'd1) * wbh;
  assign sb_first = AW'(fbgr_pkg::SbGlyphBase) + AW'(sb_prod) - AW'(wb);
  assign db_prod  = AW'((idx_q + AW'(1)) * wbh);
  assign db_first = AW'(fbgr_pkg::DbBlockBase) + AW'({nb_q, 2'b00}) + db_prod - AW'(wb);
  assign blk_addr = AW'(fbgr_pkg::DbBlockBase) + AW'({blk_q, 2'b00});

  // code block compare
  logic [15:0] ce;
  logic        hit;
  assign ce  = {rdata, ce_lo_q};
  assign hit = (code_q >= cs_q) && (code_q <= ce);

  // row mask: MSB-left bytes into LSB-left mask, clipped to the glyph width
  logic [fbgr_pkg::MaskW-1:0] raw_mask, wmask;
  logic [fbgr_pkg::MaskW:0]   wmask_full;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      raw_mask[i]     = b0_q[7-i];
      raw_mask[8 + i] = b1_q[7-i];
    end
  end
  assign wmask_full = ((fbgr_pkg::MaskW + 1)'(1) << w_q[4:0]) - (fbgr_pkg::MaskW + 1)'(1);
  assign wmask      = wmask_full[fbgr_pkg::MaskW-1:0];

  // RAM requests: loads write straight from the input
  always_comb begin
    ram_req.we    = in_xfer && (in_i.payload.func == fbgr_pkg::FuncLoad);
    ram_req.waddr = in_i.payload.load_addr;
    ram_req.wdata = in_i.payload.load_byte;
    case (state_q)
      StIdle:  ram_req.raddr = AW'(fbgr_pkg::HdrWidthAddr);
      StHdrW:  ram_req.raddr = AW'(fbgr_pkg::HdrHeightAddr);
      StHdrH:  ram_req.raddr = AW'(fbgr_pkg::HdrTypeAddr);
      StHdrT:  ram_req.raddr = AW'(fbgr_pkg::DbCountAddr);
      StBlk:   ram_req.raddr = blk_addr;
      StB1:    ram_req.raddr = blk_addr + AW'(1);
      StB2:    ram_req.raddr = blk_addr + AW'(2);
      StB3:    ram_req.raddr = blk_addr + AW'(3);
      StRow:   ram_req.raddr = row_addr_q;
      StR1:    ram_req.raddr = row_addr_q + AW'(1);
      default: ram_req.raddr = row_addr_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    x_d         = x_q;
    y_d         = y_q;
    fg_d        = fg_q;
    bg_d        = bg_q;
    w_d         = w_q;
    h_d         = h_q;
    type_d      = type_q;
    nb_d        = nb_q;
    blk_d       = blk_q;
    cs_d        = cs_q;
    ce_lo_d     = ce_lo_q;
    idx_d       = idx_q;
    row_addr_d  = row_addr_q;
    k_d         = k_q;
    b0_d        = b0_q;
    b1_d        = b1_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      StIdle: begin
        if (in_xfer && (in_i.payload.func == fbgr_pkg::FuncDraw)) begin
          code_d  = in_i.payload.char_code;
          x_d     = in_i.payload.x_pos;
          y_d     = in_i.payload.y_pos;
          fg_d    = in_i.payload.fg_color;
          bg_d    = in_i.payload.bg_color;
          state_d = StHdrW;
        end
      end
      StHdrW: begin
        w_d     = rdata;
        state_d = StHdrH;
      end
      StHdrH: begin
        h_d     = rdata;
        state_d = StHdrT;
      end
      StHdrT: begin
        type_d  = rdata;
        state_d = StChk;
      end
      StChk: begin
        nb_d  = rdata;
        blk_d = 8'd0;
        idx_d = '0;
        k_d   = 5'd0;
        if (bad_hdr) begin
          err_d   = fbgr_pkg::StReject;
          state_d = StErr;
        end else if (too_large) begin
          err_d   = fbgr_pkg::StTooLarge;
          state_d = StErr;
        end else if (type_q == fbgr_pkg::FontSingle) begin
          if (bad_sb_code) begin
            err_d   = fbgr_pkg::StReject;
            state_d = StErr;
          end else begin
            row_addr_d = sb_first;
            state_d    = StRow;
          end
        end else begin
          state_d = StBlk;
        end
      end
      StBlk: begin
        if (blk_q == nb_q) begin
          err_d   = fbgr_pkg::StReject;
          state_d = StErr;
        end else begin
          state_d = StB1;
        end
      end
      StB1: begin
        cs_d[7:0] = rdata;
        state_d   = StB2;
      end
      StB2: begin
        cs_d[15:8] = rdata;
        state_d    = StB3;
      end
      StB3: begin
        ce_lo_d = rdata;
        state_d = StB4;
      end
      StB4: begin
        if (hit) begin
          idx_d   = idx_q + AW'(code_q - cs_q);
          state_d = StMul;
        end else begin
          if (ce >= cs_q) begin
            idx_d = idx_q + AW'(17'(ce) - 17'(cs_q) + 17'd1);
          end
          blk_d   = blk_q + 8'd1;
          state_d = StBlk;
        end
      end
      StMul: begin
        row_addr_d = db_first;
        state_d    = StRow;
      end
      StRow: begin
        state_d = StR1;
      end
      StR1: begin
        b0_d    = rdata;
        state_d = StR2;
      end
      StR2: begin
        b1_d    = rdata;
        state_d = StEmit;
      end
      StEmit: begin
        if (slot_free) begin
          out_d.status    = fbgr_pkg::StRow;
          out_d.row_x     = x_q;
          out_d.row_y     = y_q + 16'(k_q);
          out_d.row_mask  = raw_mask & wmask;
          out_d.row_width = w_q[4:0];
          out_d.row_fg    = fg_q;
          out_d.row_bg    = bg_q;
          out_d.last_row  = (k_q == h_q[4:0] - 5'd1);
          out_valid_d     = 1'b1;
          k_d             = k_q + 5'd1;
          row_addr_d      = row_addr_q - AW'(wb);
          state_d         = (k_q == h_q[4:0] - 5'd1) ? StIdle : StRow;
        end
      end
      StErr: begin
        if (slot_free) begin
          out_d.status    = err_q;
          out_d.row_x     = x_q;
          out_d.row_y     = y_q;
          out_d.row_mask  = '0;
          out_d.row_width = 5'd0;
          out_d.row_fg    = fg_q;
          out_d.row_bg    = bg_q;
          out_d.last_row  = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    x_q        <= x_d;
    y_q        <= y_d;
    fg_q       <= fg_d;
    bg_q       <= bg_d;
    w_q        <= w_d;
    h_q        <= h_d;
    type_q     <= type_d;
    nb_q       <= nb_d;
    blk_q      <= blk_d;
    cs_q       <= cs_d;
    ce_lo_q    <= ce_lo_d;
    idx_q      <= idx_d;
    row_addr_q <= row_addr_d;
    k_q        <= k_d;
    b0_q       <= b0_d;
    b1_q       <= b1_d;
    err_q      <= err_d;
    out_q      <= out_d;
  end

  assign in_i.ready    = (state_q == StIdle);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef SYNTHESIS
  // font writes only happen between draws
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> state_q == StIdle)
    else $error("font write outside idle");

  // an accepted draw always starts the header read
  a_draw_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.payload.func == fbgr_pkg::FuncDraw) |=> state_q == StHdrW)
    else $error("draw did not start header read");

  // row results carry a legal glyph width
  a_row_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == fbgr_pkg::StRow) |->
      (out_q.row_width != 5'd0 && out_q.row_width <= 5'(fbgr_pkg::MaxGlyphW)))
    else $error("row result with bad width");

  // row counter stays within the glyph height
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> k_q < h_q[4:0])
    else $error("row counter past glyph height");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_font_glyph_rows_unit: font loads, draws and
// row checks against a predictor. Depends on fbgr_pkg, fbgr_in_if, fbgr_out_if and the RTL.
module testbench;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned TotalItems   = 170;

  // handshake idling profile, carried with each queued item
  typedef enum logic [1:0] {
    IdleNone,
    IdleSrc,
    IdleSnk,
    IdleBoth
  } idle_mode_e;

  typedef struct {
    fbgr_pkg::in_item_t item;
    idle_mode_e         mode;
    bit                 hold_rx;  // receiver holds off once this transfer is taken
    bit                 drain;    // sender waits for all rows before offering this
  } stim_t;

  typedef logic [7:0] byte_map_t [int unsigned];

  logic clk_i;
  logic rst_ni;

  fbgr_in_if  in_bus ();
  fbgr_out_if out_bus ();

  bitmap_font_glyph_rows_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // font image as planned by the generator, and as seen by the predictor
  byte_map_t plan_img;
  byte_map_t model_img;

  stim_t               stim_q [$];
  fbgr_pkg::out_item_t expected_rows [$];
  fbgr_pkg::out_item_t row_buf [$];
  int unsigned         unread_q [$];

  stim_t       cur_stim;
  idle_mode_e  rx_mode;
  idle_mode_e  gen_mode;
  bit          gen_hold;
  bit          gen_drain;
  bit          hold_start;
  int unsigned hold_cnt;
  int unsigned stim_count;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // code blocks of the double-byte font being built
  logic [15:0] blk_lo [$];
  logic [15:0] blk_hi [$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Glyph row predictor
  // ---------------------------------------------------------------------------

  // Image read, address wrapped to the image size. Bytes never written are
  // logged so the generator can load them before the draw goes out.
  function automatic logic [7:0] img_rd(input bit plan, input longint unsigned addr);
    int unsigned a;
    a = int'(addr % longint'(fbgr_pkg::FontBytes));
    if (plan) begin
      if (plan_img.exists(a)) return plan_img[a];
    end else begin
      if (model_img.exists(a)) return model_img[a];
    end
    unread_q.push_back(a);
    return 8'h00;
  endfunction

  // Works out the rows one item gives; they land in row_buf.
  function automatic void glyph_rows(input bit plan, input fbgr_pkg::in_item_t it);
    int unsigned                w, h, ftype, wb, nb, r;
    longint unsigned            base, idx, cs, ce, a, code;
    logic [7:0]                 b8;
    logic [fbgr_pkg::MaskW-1:0] mask;
    bit                         found;
    fbgr_pkg::out_item_t        o;
    row_buf.delete();
    if (it.func == fbgr_pkg::FuncLoad) begin
      if (plan) plan_img[it.load_addr] = it.load_byte;
      else      model_img[it.load_addr] = it.load_byte;
      return;
    end
    o           = '0;
    o.row_x     = it.x_pos;
    o.row_y     = it.y_pos;
    o.row_fg    = it.fg_color;
    o.row_bg    = it.bg_color;
    o.last_row  = 1'b1;
    w     = img_rd(plan, fbgr_pkg::HdrWidthAddr);
    h     = img_rd(plan, fbgr_pkg::HdrHeightAddr);
    ftype = img_rd(plan, fbgr_pkg::HdrTypeAddr);
    // bad type or empty glyph beats an oversize one
    if (ftype > fbgr_pkg::FontDouble || w == 0 || h == 0) begin
      o.status = fbgr_pkg::StReject;
      row_buf.push_back(o);
      return;
    end
    if (w > fbgr_pkg::MaxGlyphW || h > fbgr_pkg::MaxGlyphH) begin
      o.status = fbgr_pkg::StTooLarge;
      row_buf.push_back(o);
      return;
    end
    wb   = (w + 7) / 8;
    code = it.char_code;
    if (ftype == fbgr_pkg::FontSingle) begin
      if (code > 255 || (code >= fbgr_pkg::LeadLo1 && code <= fbgr_pkg::LeadHi1) ||
          (code >= fbgr_pkg::LeadLo2 && code <= fbgr_pkg::LeadHi2)) begin
        o.status = fbgr_pkg::StReject;
        row_buf.push_back(o);
        return;
      end
      base = fbgr_pkg::SbGlyphBase + code * wb * h;
    end else begin
      nb    = img_rd(plan, fbgr_pkg::DbCountAddr);
      idx   = 0;
      found = 1'b0;
      for (int b = 0; b < nb && !found; b++) begin
        a  = fbgr_pkg::DbBlockBase + 4 * b;
        cs = {img_rd(plan, a + 1), img_rd(plan, a)};
        ce = {img_rd(plan, a + 3), img_rd(plan, a + 2)};
        if (code >= cs && code <= ce) begin
          idx  += code - cs;
          found = 1'b1;
        end else if (ce >= cs) begin
          // inverted blocks hold nothing and add nothing
          idx += ce - cs + 1;
        end
      end
      if (!found) begin
        o.status = fbgr_pkg::StReject;
        row_buf.push_back(o);
        return;
      end
      base = fbgr_pkg::DbBlockBase + 4 * nb + idx * wb * h;
    end
    // bottom bitmap row first, screen rows counting up from y_pos
    for (int k = 0; k < h; k++) begin
      r    = h - 1 - k;
      mask = '0;
      for (int j = 0; j < w; j++) begin
        b8 = img_rd(plan, base + longint'(r) * wb + (j >> 3));
        if (b8[7 - (j & 7)]) mask[j] = 1'b1;
      end
      o.status    = fbgr_pkg::StRow;
      o.row_y     = it.y_pos + 16'(k);
      o.row_mask  = mask;
      o.row_width = 5'(w);
      o.last_row  = (k == h - 1);
      row_buf.push_back(o);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic fbgr_pkg::in_item_t rand_item();
    fbgr_pkg::in_item_t it;
    it.func      = 1'($urandom);
    it.load_addr = fbgr_pkg::AddrW'($urandom);
    it.load_byte = 8'($urandom);
    it.char_code = 16'($urandom);
    it.x_pos     = 16'($urandom);
    it.y_pos     = 16'($urandom);
    it.fg_color  = 16'($urandom);
    it.bg_color  = 16'($urandom);
    return it;
  endfunction

  task automatic push_stim(input fbgr_pkg::in_item_t it);
    stim_t s;
    s.item    = it;
    s.mode    = gen_mode;
    s.hold_rx = gen_hold;
    s.drain   = gen_drain;
    gen_hold  = 1'b0;
    gen_drain = 1'b0;
    stim_q.push_back(s);
    stim_count++;
    if (it.func == fbgr_pkg::FuncLoad) plan_img[it.load_addr] = it.load_byte;
  endtask

  task automatic font_byte(input int unsigned addr, input logic [7:0] val);
    fbgr_pkg::in_item_t it;
    it           = rand_item();
    it.func      = fbgr_pkg::FuncLoad;
    it.load_addr = fbgr_pkg::AddrW'(addr);
    it.load_byte = val;
    push_stim(it);
  endtask

  task automatic font_header(input int unsigned ftype, input int unsigned w,
                             input int unsigned h);
    font_byte(fbgr_pkg::HdrWidthAddr, 8'(w));
    font_byte(fbgr_pkg::HdrHeightAddr, 8'(h));
    font_byte(fbgr_pkg::HdrTypeAddr, 8'(ftype));
  endtask

  // block count and little-endian start/end pairs from blk_lo/blk_hi
  task automatic db_table();
    font_byte(fbgr_pkg::DbCountAddr, 8'(blk_lo.size()));
    foreach (blk_lo[b]) begin
      font_byte(fbgr_pkg::DbBlockBase + 4 * b,     blk_lo[b][7:0]);
      font_byte(fbgr_pkg::DbBlockBase + 4 * b + 1, blk_lo[b][15:8]);
      font_byte(fbgr_pkg::DbBlockBase + 4 * b + 2, blk_hi[b][7:0]);
      font_byte(fbgr_pkg::DbBlockBase + 4 * b + 3, blk_hi[b][15:8]);
    end
  endtask

  // A draw goes out only once every byte it reads has been loaded: glyph
  // bytes still missing are filled with random data first.
  task automatic draw_at(input logic [15:0] code, input logic [15:0] x,
                         input logic [15:0] y, input logic [15:0] fg,
                         input logic [15:0] bg);
    fbgr_pkg::in_item_t it;
    it           = rand_item();
    it.func      = fbgr_pkg::FuncDraw;
    it.char_code = code;
    it.x_pos     = x;
    it.y_pos     = y;
    it.fg_color  = fg;
    it.bg_color  = bg;
    for (int pass = 0; pass < 8; pass++) begin
      unread_q.delete();
      glyph_rows(1'b1, it);
      if (unread_q.size() == 0) break;
      foreach (unread_q[i])
        if (!plan_img.exists(unread_q[i])) font_byte(unread_q[i], 8'($urandom));
    end
    push_stim(it);
  endtask

  task automatic draw_rand(input logic [15:0] code);
    draw_at(code, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic directed_items();
    // small single-byte font; the long receiver hold-off starts here
    gen_mode = IdleNone;
    gen_hold = 1'b1;
    font_header(fbgr_pkg::FontSingle, 8, 2);
    draw_at(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    draw_at(16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);  // row_y wraps
    draw_rand(16'h0080);
    draw_rand(16'h00FD);
    // lead-byte range edges and codes above one byte
    draw_rand(16'h0081);
    draw_rand(16'h009F);
    draw_rand(16'h00E0);
    draw_rand(16'h00FC);
    draw_rand(16'h0100);
    // glyph sizes: odd width over a byte, smallest
    gen_mode  = IdleSrc;
    gen_drain = 1'b1;
    font_header(fbgr_pkg::FontSingle, 9, 3);
    draw_rand(16'h007F);
    font_header(fbgr_pkg::FontSingle, 1, 1);
    draw_rand(16'h0020);
    // header errors: empty glyph, unknown type, too large, type before size
    gen_mode = IdleSnk;
    font_header(fbgr_pkg::FontSingle, 0, 4);
    draw_rand(16'h0041);
    font_header(fbgr_pkg::FontSingle, 4, 0);
    draw_rand(16'h0041);
    font_header(2, 8, 8);
    draw_rand(16'h0041);
    font_header(fbgr_pkg::FontSingle, 17, 8);
    draw_rand(16'h0041);
    font_header(fbgr_pkg::FontDouble, 8, 17);
    draw_rand(16'h0041);
    font_header(8'hFF, 255, 255);
    draw_rand(16'h0041);
    // double-byte font, middle block inverted
    gen_mode = IdleBoth;
    font_header(fbgr_pkg::FontDouble, 12, 2);
    blk_lo = '{16'h8140, 16'h9000, 16'h8180};
    blk_hi = '{16'h817E, 16'h8FFF, 16'h81FF};
    db_table();
    draw_rand(16'h8180);
    draw_rand(16'h81FF);
    draw_rand(16'h817F);
    // no blocks at all
    blk_lo.delete();
    blk_hi.delete();
    db_table();
    draw_rand(16'h8140);
    // largest glyph, one block over the whole code space; the glyph address
    // wraps round the image and reads back the header
    font_header(fbgr_pkg::FontDouble, 16, 16);
    blk_lo = '{16'h0000};
    blk_hi = '{16'hFFFF};
    db_table();
    draw_rand(16'hFFFF);
  endtask

  task automatic random_round(input int unsigned round);
    int unsigned kind, ftype, w, h, nb, lo, hi, roll, b;
    logic [15:0] pool [4];
    logic [15:0] code;
    gen_mode  = idle_mode_e'(round % 4);
    gen_drain = 1'b1;
    kind      = (round == 0) ? 0 : $urandom_range(0, 9);
    ftype     = $urandom_range(0, 1);
    w         = $urandom_range(1, 16);
    h         = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 16);
    case (kind)
      7: ftype = $urandom_range(2, 255);
      8: if ($urandom_range(0, 1)) w = 0; else h = 0;
      9: if ($urandom_range(0, 1)) w = $urandom_range(17, 255);
         else h = $urandom_range(17, 255);
      default: ;
    endcase
    font_header(ftype, w, h);
    if (ftype == fbgr_pkg::FontDouble) begin
      blk_lo.delete();
      blk_hi.delete();
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      for (int i = 0; i < nb; i++) begin
        lo = $urandom_range(0, 65535);
        if ($urandom_range(0, 4) == 0) hi = (lo - $urandom_range(1, 20)) & 16'hFFFF;
        else hi = (lo + $urandom_range(0, 40) > 65535) ? 65535 : lo + $urandom_range(0, 40);
        blk_lo.push_back(16'(lo));
        blk_hi.push_back(16'(hi));
      end
      db_table();
    end
    foreach (pool[i]) pool[i] = 16'($urandom_range(0, 255));
    // first item after setup starts the long receiver hold-off
    if (round == 0) gen_hold = 1'b1;
    for (int n = 0; n < 8; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        // stray load clear of the header and code-block table
        font_byte($urandom_range(128, fbgr_pkg::FontBytes - 1), 8'($urandom));
      end else begin
        code = 16'($urandom);
        if (roll < 80) begin
          if (ftype == fbgr_pkg::FontDouble) begin
            for (int t = 0; t < 8 && blk_lo.size() != 0; t++) begin
              b = $urandom_range(0, blk_lo.size() - 1);
              if (blk_hi[b] >= blk_lo[b]) begin
                code = blk_lo[b] + 16'($urandom_range(0, blk_hi[b] - blk_lo[b]));
                break;
              end
            end
          end else begin
            code = pool[$urandom_range(0, 3)];
          end
        end
        draw_rand(code);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------

  function automatic bit idle_roll(input idle_mode_e m, input bit sink);
    int unsigned pct;
    case (m)
      IdleSrc:  pct = sink ? 0 : 49;
      IdleSnk:  pct = sink ? 49 : 0;
      IdleBoth: pct = 11;
      default:  pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items; the predictor runs on each accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bit took;
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.payload <= '0;
      hold_start     <= 1'b0;
      rx_mode        <= IdleNone;
    end else begin
      took = in_bus.valid && in_bus.ready;
      if (took) begin
        glyph_rows(1'b0, cur_stim.item);
        foreach (row_buf[i]) expected_rows.push_back(row_buf[i]);
        rx_mode <= cur_stim.mode;
      end
      hold_start <= took && cur_stim.hold_rx;
      // valid only drops when the current item has gone, so it never
      // toggles within one step
      if (!in_bus.valid || took) begin
        if (stim_q.size() != 0 && !(stim_q[0].drain && expected_rows.size() != 0) &&
            !idle_roll(stim_q[0].mode, 1'b0)) begin
          cur_stim = stim_q.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.payload <= cur_stim.item;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
    end else if (hold_start) begin
      hold_cnt <= HoldCycles;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each row transfer against the oldest expected row
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    fbgr_pkg::out_item_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_rows.size() == 0) begin
          $error("row transfer with nothing pending: status %0d row_y 0x%0h",
                 out_bus.payload.status, out_bus.payload.row_y);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          check_field("status",    16'(want.status),    16'(out_bus.payload.status));
          check_field("row_x",     want.row_x,          out_bus.payload.row_x);
          check_field("row_y",     want.row_y,          out_bus.payload.row_y);
          check_field("row_mask",  want.row_mask,       out_bus.payload.row_mask);
          check_field("row_width", 16'(want.row_width), 16'(out_bus.payload.row_width));
          check_field("row_fg",    want.row_fg,         out_bus.payload.row_fg);
          check_field("row_bg",    want.row_bg,         out_bus.payload.row_bg);
          check_field("last_row",  16'(want.last_row),  16'(out_bus.payload.last_row));
        end
      end
      out_bus.ready <= (hold_cnt == 0) && !idle_roll(rx_mode, 1'b1);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build all stimulus, release reset, then wait for the last row
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned round;
    rst_ni     = 1'b0;
    gen_mode   = IdleNone;
    gen_hold   = 1'b0;
    gen_drain  = 1'b0;
    stim_count = 0;

    directed_items();
    round = 0;
    do begin
      random_round(round);
      round++;
    end while (stim_count < TotalItems);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (stim_q.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== bitmap_font_glyph_rows_unit.f =====
rtl/fbgr_pkg.sv
rtl/fbgr_in_if.sv
rtl/fbgr_out_if.sv
rtl/fbgr_font_ram.sv
rtl/bitmap_font_glyph_rows_unit.sv
verif/testbench.sv
